FILE: sv/frs_pkg.sv
// frs_pkg: shared types and constants of the failover replacement selector
// candidate and result beat structs, config register indexes, verdict and reason codes
// no dependencies
package frs_pkg;

    localparam int MAX_COUNT_DEF = 255;
    localparam int TOT_W         = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    // config register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SUBJECT_LINK      = 3'd0,
        CFG_MIN_CONFIDENCE    = 3'd1,
        CFG_ALLOW_DEGRADED    = 3'd2,
        CFG_REQUIRE_ADJACENCY = 3'd3,
        CFG_MIN_CAPACITY      = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        VERDICT_ELIGIBLE      = 2'd0,
        VERDICT_DISPROVEN     = 2'd1,
        VERDICT_INDETERMINATE = 2'd2
    } verdict_t;

    typedef enum logic [3:0] {
        RSN_ELIGIBLE     = 4'd0,
        RSN_SUBJECT      = 4'd1,
        RSN_CONFLICT     = 4'd2,
        RSN_MISSING      = 4'd3,
        RSN_GEN_MISMATCH = 4'd4,
        RSN_PRIOR        = 4'd5,
        RSN_STALE        = 4'd6,
        RSN_LOW_CONF     = 4'd7,
        RSN_UNKNOWN      = 4'd8,
        RSN_UNUSABLE     = 4'd9,
        RSN_DEGRADED     = 4'd10,
        RSN_CAPACITY     = 4'd11,
        RSN_UNAUTHORIZED = 4'd12,
        RSN_EMPTY        = 4'd13
    } reason_t;

    typedef enum logic [1:0] {
        STATUS_SELECTED      = 2'd0,
        STATUS_INFEASIBLE    = 2'd1,
        STATUS_INDETERMINATE = 2'd2,
        STATUS_EMPTY         = 2'd3
    } status_t;

    // evidence flag bit positions
    localparam int EV_CONFLICTED = 0;
    localparam int EV_PRESENT    = 1;
    localparam int EV_GEN_ASSERT = 2;
    localparam int EV_GEN_MATCH  = 3;

    // freshness codes
    localparam logic [1:0] FRESH_CURRENT = 2'd0;
    localparam logic [1:0] FRESH_PRIOR   = 2'd1;

    // link state codes, anything from unknown up counts as unknown
    localparam logic [2:0] LS_UP       = 3'd0;
    localparam logic [2:0] LS_DEGRADED = 3'd1;
    localparam logic [2:0] LS_DOWN     = 3'd2;
    localparam logic [2:0] LS_UNUSABLE = 3'd3;
    localparam logic [2:0] LS_UNKNOWN  = 3'd4;

    typedef struct packed {
        logic        empty_run;
        logic [15:0] link_id;
        logic [31:0] link_gen;
        logic [3:0]  evidence_flags;
        logic [1:0]  freshness;
        logic [15:0] confidence;
        logic [2:0]  link_state;
        logic [31:0] age;
        logic [31:0] capacity;
        logic [31:0] cost;
        logic        authorized;
        logic        last_item;
    } frs_in_t;

    typedef struct packed {
        verdict_t           verdict;
        reason_t            reason_code;
        logic               run_done;
        status_t            run_status;
        logic [TOT_W-1:0]   eligible_total;
        logic [TOT_W-1:0]   disproven_total;
        logic [TOT_W-1:0]   undecided_total;
        logic [15:0]        chosen_link;
        logic [31:0]        chosen_gen;
    } frs_out_t;

    typedef struct packed {
        logic [15:0] subject_link;
        logic [15:0] min_confidence;
        logic        allow_degraded;
        logic        require_adjacency;
        logic [31:0] min_capacity;
    } frs_cfg_t;

    // classification handed from the check chain to the run tracker
    typedef struct packed {
        verdict_t verdict;
        reason_t  reason;
    } frs_class_t;

endpackage

FILE: sv/failover_replacement_selector.sv
// failover_replacement_selector: top level, config registers and two-register pipeline
// instantiates frs_classify and frs_tracker; uses frs_pkg
//
// channel  | signals                            | direction | beat
// ---------+------------------------------------+-----------+-------------------------------
// cand     | cand_valid, cand_stall, cand       | in        | one candidate or empty-run mark
// res      | res_valid, res_stall, res          | out       | one result per candidate beat
// cfg      | cfg_valid, cfg_ready, cfg_index,   | in        | one register write
//          | cfg_data                           |           |
//
// each beat is held in the input register, then is checked and ranked
// against the running best on its way into the result register;
// a new beat is taken every cycle unless cand_stall is high
// reset clears config registers, run state and both valid flags
// cand_stall rises only while the input register is full and the result
// register holds a beat that res_stall keeps from leaving
module failover_replacement_selector
    import frs_pkg::*;
#(
    parameter int MAX_COUNT = MAX_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // candidate channel
    input  logic                  cand_valid,
    output logic                  cand_stall,
    input  frs_in_t               cand,
    // result channel
    output logic                  res_valid,
    input  logic                  res_stall,
    output frs_out_t              res,
    // config write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    frs_cfg_t   cfg_reg, cfg_next;
    logic       s1_valid_reg, s1_valid_next;
    frs_in_t    s1_item_reg;
    logic       res_valid_reg, res_valid_next;
    frs_out_t   res_reg;

    logic       advance;   // result register can take a beat this cycle
    logic       step;      // beat moves from input register to result register
    logic       load;      // input register takes a beat
    frs_class_t cls;
    frs_out_t   result;

    // config writes are always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SUBJECT_LINK:      cfg_next.subject_link      = cfg_data[15:0];
                CFG_MIN_CONFIDENCE:    cfg_next.min_confidence    = cfg_data[15:0];
                CFG_ALLOW_DEGRADED:    cfg_next.allow_degraded    = cfg_data[0];
                CFG_REQUIRE_ADJACENCY: cfg_next.require_adjacency = cfg_data[0];
                CFG_MIN_CAPACITY:      cfg_next.min_capacity      = cfg_data[31:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    // pipeline control
    always_comb
    begin
        advance        = !res_valid_reg || !res_stall;
        step           = s1_valid_reg && advance;
        cand_stall     = s1_valid_reg && !advance;
        load           = !cand_stall;
        s1_valid_next  = load ? cand_valid : s1_valid_reg;
        res_valid_next = advance ? s1_valid_reg : res_valid_reg;
    end

    frs_classify u_classify
    (
        .item (s1_item_reg),
        .cfg  (cfg_reg),
        .cls  (cls)
    );

    frs_tracker #(
        .MAX_COUNT (MAX_COUNT)
    ) u_tracker
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (s1_item_reg),
        .cls    (cls),
        .result (result)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load && cand_valid)
        begin
            s1_item_reg <= cand;
        end
        if (step)
        begin
            res_reg <= result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: sv/frs_classify.sv
// frs_classify: ordered check chain giving one candidate's verdict and reason
// combinational; uses frs_pkg
module frs_classify
    import frs_pkg::*;
(
    input  frs_in_t    item,
    input  frs_cfg_t   cfg,
    output frs_class_t cls
);

    always_comb
    begin
        // first check that fires decides
        priority if (item.link_id == cfg.subject_link)
        begin
            cls = '{VERDICT_DISPROVEN, RSN_SUBJECT};
        end
        else if (item.evidence_flags[EV_CONFLICTED])
        begin
            cls = '{VERDICT_INDETERMINATE, RSN_CONFLICT};
        end
        else if (!item.evidence_flags[EV_PRESENT])
        begin
            cls = '{VERDICT_INDETERMINATE, RSN_MISSING};
        end
        else if (item.evidence_flags[EV_GEN_ASSERT] && !item.evidence_flags[EV_GEN_MATCH])
        begin
            cls = '{VERDICT_INDETERMINATE, RSN_GEN_MISMATCH};
        end
        else if (item.freshness == FRESH_PRIOR)
        begin
            cls = '{VERDICT_INDETERMINATE, RSN_PRIOR};
        end
        else if (item.freshness != FRESH_CURRENT)
        begin
            // expired and future both count as stale
            cls = '{VERDICT_INDETERMINATE, RSN_STALE};
        end
        else if (item.confidence < cfg.min_confidence)
        begin
            cls = '{VERDICT_INDETERMINATE, RSN_LOW_CONF};
        end
        else if (item.link_state >= LS_UNKNOWN)
        begin
            cls = '{VERDICT_INDETERMINATE, RSN_UNKNOWN};
        end
        else if (item.link_state == LS_DOWN || item.link_state == LS_UNUSABLE)
        begin
            cls = '{VERDICT_DISPROVEN, RSN_UNUSABLE};
        end
        else if (item.link_state == LS_DEGRADED && !cfg.allow_degraded)
        begin
            cls = '{VERDICT_DISPROVEN, RSN_DEGRADED};
        end
        else if (item.capacity < cfg.min_capacity)
        begin
            cls = '{VERDICT_DISPROVEN, RSN_CAPACITY};
        end
        else if (cfg.require_adjacency && !item.authorized)
        begin
            cls = '{VERDICT_DISPROVEN, RSN_UNAUTHORIZED};
        end
        else
        begin
            cls = '{VERDICT_ELIGIBLE, RSN_ELIGIBLE};
        end
    end

endmodule

FILE: sv/frs_tracker.sv
// frs_tracker: per-run verdict counters, running best candidate and run status
// state updates on each step; uses frs_pkg
module frs_tracker
    import frs_pkg::*;
#(
    parameter int MAX_COUNT = MAX_COUNT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  frs_in_t    item,
    input  frs_class_t cls,
    output frs_out_t   result
);

    localparam int CNT_W = $clog2(MAX_COUNT + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_COUNT);

    // best key fields, ordered so that a plain greater-than ranks candidates
    typedef struct packed {
        logic        authorized;
        logic [15:0] confidence;
        logic [31:0] age_inv;
        logic [31:0] capacity;
        logic [31:0] cost_inv;
        logic [31:0] gen;
        logic [15:0] link_inv;
    } key_t;

    logic             best_valid_reg, best_valid_next;
    key_t             lead_key_reg, lead_key_next;
    logic [CNT_W-1:0] elig_cnt_reg, elig_cnt_next;
    logic [CNT_W-1:0] disp_cnt_reg, disp_cnt_next;
    logic [CNT_W-1:0] und_cnt_reg, und_cnt_next;

    key_t cand_key;
    logic take_new;
    logic end_run;

    always_comb
    begin
        cand_key = '{item.authorized, item.confidence, ~item.age, item.capacity,
                     ~item.cost, item.link_gen, ~item.link_id};
        // strict compare keeps the earlier candidate on equal keys
        take_new = (cls.verdict == VERDICT_ELIGIBLE)
                   && (!best_valid_reg || (cand_key > lead_key_reg));

        best_valid_next = best_valid_reg || take_new;
        lead_key_next   = take_new ? cand_key : lead_key_reg;

        elig_cnt_next = elig_cnt_reg;
        disp_cnt_next = disp_cnt_reg;
        und_cnt_next  = und_cnt_reg;
        unique case (cls.verdict)
            VERDICT_ELIGIBLE:
            begin
                elig_cnt_next = (elig_cnt_reg < CNT_MAX) ? elig_cnt_reg + CNT_W'(1) : CNT_MAX;
            end
            VERDICT_DISPROVEN:
            begin
                disp_cnt_next = (disp_cnt_reg < CNT_MAX) ? disp_cnt_reg + CNT_W'(1) : CNT_MAX;
            end
            default:
            begin
                und_cnt_next = (und_cnt_reg < CNT_MAX) ? und_cnt_reg + CNT_W'(1) : CNT_MAX;
            end
        endcase

        end_run = item.empty_run || item.last_item;

        if (item.empty_run)
        begin
            result = '{VERDICT_INDETERMINATE, RSN_EMPTY, 1'b1, STATUS_EMPTY,
                       '0, '0, '0, '0, '0};
        end
        else
        begin
            result.verdict         = cls.verdict;
            result.reason_code     = cls.reason;
            result.run_done        = item.last_item;
            result.eligible_total  = TOT_W'(elig_cnt_next);
            result.disproven_total = TOT_W'(disp_cnt_next);
            result.undecided_total = TOT_W'(und_cnt_next);
            result.run_status      = STATUS_SELECTED;
            result.chosen_link     = '0;
            result.chosen_gen      = '0;
            if (item.last_item)
            begin
                priority if (best_valid_next)
                begin
                    result.run_status  = STATUS_SELECTED;
                    result.chosen_link = ~lead_key_next.link_inv;
                    result.chosen_gen  = lead_key_next.gen;
                end
                else if (und_cnt_next != '0)
                begin
                    result.run_status = STATUS_INDETERMINATE;
                end
                else
                begin
                    result.run_status = STATUS_INFEASIBLE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_valid_reg <= 1'b0;
            lead_key_reg   <= '0;
            elig_cnt_reg   <= '0;
            disp_cnt_reg   <= '0;
            und_cnt_reg    <= '0;
        end
        else if (step)
        begin
            if (end_run)
            begin
                best_valid_reg <= 1'b0;
                lead_key_reg   <= '0;
                elig_cnt_reg   <= '0;
                disp_cnt_reg   <= '0;
                und_cnt_reg    <= '0;
            end
            else
            begin
                best_valid_reg <= best_valid_next;
                lead_key_reg   <= lead_key_next;
                elig_cnt_reg   <= elig_cnt_next;
                disp_cnt_reg   <= disp_cnt_next;
                und_cnt_reg    <= und_cnt_next;
            end
        end
    end

endmodule
